### design/i2c_ras_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer package
// Types, status codes, action codes and error codes shared by the design.
// ----------------------------------------------------------------------------
package i2c_ras_pkg;

   localparam int CMD_W    = 2;
   localparam int DEV_W    = 7;
   localparam int BYTE_W   = 8;
   localparam int ACTION_W = 3;
   localparam int ERROR_W  = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_STATUS = 2'd2
   } command_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_START     = 4'd1,
      PH_ADDRW     = 4'd2,
      PH_REG       = 4'd3,
      PH_RESTART   = 4'd4,
      PH_ADDRR     = 4'd5,
      PH_DATA_ACK  = 4'd6,
      PH_DATA_LAST = 4'd7,
      PH_WDATA     = 4'd8
   } phase_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_SEND  = 3'd2,
      ACT_RACK  = 3'd3,
      ACT_RNACK = 3'd4,
      ACT_STOP  = 3'd5
   } action_type;

   typedef enum logic [ERROR_W-1:0] {
      ERR_OK        = 4'd0,
      ERR_START     = 4'd1,
      ERR_ADDRW     = 4'd2,
      ERR_REG       = 4'd3,
      ERR_RESTART   = 4'd4,
      ERR_ADDRR     = 4'd5,
      ERR_DATA_ACK  = 4'd6,
      ERR_DATA_LAST = 4'd7,
      ERR_WDATA     = 4'd8
   } error_type;

   localparam logic [BYTE_W-1:0] ST_MASK     = 8'hF8;
   localparam logic [BYTE_W-1:0] ST_START    = 8'h08;
   localparam logic [BYTE_W-1:0] ST_REPSTART = 8'h10;
   localparam logic [BYTE_W-1:0] ST_SLAW_ACK = 8'h18;
   localparam logic [BYTE_W-1:0] ST_TXD_ACK  = 8'h28;
   localparam logic [BYTE_W-1:0] ST_SLAR_ACK = 8'h40;
   localparam logic [BYTE_W-1:0] ST_RXD_ACK  = 8'h50;
   localparam logic [BYTE_W-1:0] ST_RXD_NACK = 8'h58;

endpackage

### design/i2c_ras_channels.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer channels
// Valid/ready channels for the event input and the result output.
// ----------------------------------------------------------------------------
interface i2c_ras_req_if;
   import i2c_ras_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [DEV_W-1:0]  device;
   logic [BYTE_W-1:0] reg_address;
   logic [BYTE_W-1:0] byte_count;
   logic [BYTE_W-1:0] write_value;
   logic [BYTE_W-1:0] bus_status;
   logic [BYTE_W-1:0] received_byte;

   modport source (output valid, command, device, reg_address, byte_count,
                   write_value, bus_status, received_byte, input ready);
   modport sink   (input valid, command, device, reg_address, byte_count,
                   write_value, bus_status, received_byte, output ready);
endinterface

interface i2c_ras_rsp_if;
   import i2c_ras_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   tx_byte;
   logic                data_valid;
   logic [BYTE_W-1:0]   data_byte;
   logic [BYTE_W-1:0]   data_index;
   logic                done_res;
   logic [ERROR_W-1:0]  error_code;

   modport source (output valid, action, tx_byte, data_valid, data_byte,
                   data_index, done_res, error_code, input ready);
   modport sink   (input valid, action, tx_byte, data_valid, data_byte,
                   data_index, done_res, error_code, output ready);
endinterface

### design/i2c_register_access_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer
// Steps a byte-level I2C master through register read and write transactions.
// A result, if any, is registered and shown on rsp_ch the cycle after its event.
// Throughput: one event per cycle; a held result stalls req_ch until rsp_ch.ready.
// Reset: synchronous, active high; phase returns to idle, rsp_ch empties.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer_top (
   input logic            clock,
   input logic            reset,
   i2c_ras_req_if.sink    req_ch,
   i2c_ras_rsp_if.source  rsp_ch
);
   import i2c_ras_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [DEV_W-1:0]  target_device_ff, target_device_in;
   logic [BYTE_W-1:0] target_register_ff, target_register_in;
   logic [BYTE_W-1:0] pending_write_ff, pending_write_in;
   logic [BYTE_W-1:0] burst_length_ff, burst_length_in;
   logic [BYTE_W-1:0] byte_position_ff, byte_position_in;
   logic              is_read_ff, is_read_in;

   logic              out_valid_ff;
   action_type        action_ff, action_in;
   logic [BYTE_W-1:0] tx_byte_ff, tx_byte_in;
   logic              data_valid_ff, data_valid_in;
   logic [BYTE_W-1:0] data_byte_ff, data_byte_in;
   logic [BYTE_W-1:0] data_index_ff, data_index_in;
   logic              done_res_ff, done_res_in;
   error_type         error_code_ff, error_code_in;

   logic              emit;
   logic              req_xfer;
   logic [BYTE_W-1:0] st;
   logic [BYTE_W-1:0] addr_w;
   logic [BYTE_W-1:0] pos_next;
   logic [BYTE_W:0]   pos_plus_one;

   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign st           = req_ch.bus_status & ST_MASK;
   assign addr_w       = {target_device_ff, 1'b0};
   assign pos_next     = byte_position_ff + 8'd1;
   assign pos_plus_one = {1'b0, pos_next} + 9'd1;

   always_comb begin
      phase_in           = phase_ff;
      target_device_in   = target_device_ff;
      target_register_in = target_register_ff;
      pending_write_in   = pending_write_ff;
      burst_length_in    = burst_length_ff;
      byte_position_in   = byte_position_ff;
      is_read_in         = is_read_ff;
      emit               = 1'b0;
      action_in          = ACT_NONE;
      tx_byte_in         = '0;
      data_valid_in      = 1'b0;
      data_byte_in       = '0;
      data_index_in      = '0;
      done_res_in        = 1'b0;
      error_code_in      = ERR_OK;

      if (req_ch.command == CMD_READ || req_ch.command == CMD_WRITE) begin
         if (phase_ff == PH_IDLE) begin
            target_device_in   = req_ch.device;
            target_register_in = req_ch.reg_address;
            if (req_ch.command == CMD_READ) begin
               burst_length_in = (req_ch.byte_count == '0) ? 8'd1 : req_ch.byte_count;
               is_read_in      = 1'b1;
            end else begin
               pending_write_in = req_ch.write_value;
               is_read_in       = 1'b0;
            end
            byte_position_in = '0;
            phase_in         = PH_START;
            emit             = 1'b1;
            action_in        = ACT_START;
         end
      end else if (req_ch.command == CMD_STATUS && phase_ff != PH_IDLE) begin
         emit = 1'b1;
         case (phase_ff)
            PH_START: begin
               if (st != ST_START && st != ST_REPSTART) begin
                  error_code_in = ERR_START;
               end else begin
                  phase_in   = PH_ADDRW;
                  action_in  = ACT_SEND;
                  tx_byte_in = addr_w;
               end
            end
            PH_ADDRW: begin
               if (st != ST_SLAW_ACK) begin
                  error_code_in = ERR_ADDRW;
               end else begin
                  phase_in   = PH_REG;
                  action_in  = ACT_SEND;
                  tx_byte_in = target_register_ff;
               end
            end
            PH_REG: begin
               if (st != ST_TXD_ACK) begin
                  error_code_in = ERR_REG;
               end else if (is_read_ff) begin
                  phase_in  = PH_RESTART;
                  action_in = ACT_START;
               end else begin
                  phase_in   = PH_WDATA;
                  action_in  = ACT_SEND;
                  tx_byte_in = pending_write_ff;
               end
            end
            PH_RESTART: begin
               if (st != ST_REPSTART) begin
                  error_code_in = ERR_RESTART;
               end else begin
                  phase_in   = PH_ADDRR;
                  action_in  = ACT_SEND;
                  tx_byte_in = addr_w | 8'h01;
               end
            end
            PH_ADDRR: begin
               if (st != ST_SLAR_ACK) begin
                  error_code_in = ERR_ADDRR;
               end else begin
                  byte_position_in = '0;
                  if (burst_length_ff > 8'd1) begin
                     phase_in  = PH_DATA_ACK;
                     action_in = ACT_RACK;
                  end else begin
                     phase_in  = PH_DATA_LAST;
                     action_in = ACT_RNACK;
                  end
               end
            end
            PH_DATA_ACK: begin
               if (st != ST_RXD_ACK) begin
                  error_code_in = ERR_DATA_ACK;
               end else begin
                  byte_position_in = pos_next;
                  data_valid_in    = 1'b1;
                  data_byte_in     = req_ch.received_byte;
                  data_index_in    = byte_position_ff;
                  if (pos_plus_one < {1'b0, burst_length_ff}) begin
                     action_in = ACT_RACK;
                  end else begin
                     phase_in  = PH_DATA_LAST;
                     action_in = ACT_RNACK;
                  end
               end
            end
            PH_DATA_LAST: begin
               if (st != ST_RXD_NACK) begin
                  error_code_in = ERR_DATA_LAST;
               end else begin
                  phase_in      = PH_IDLE;
                  action_in     = ACT_STOP;
                  data_valid_in = 1'b1;
                  data_byte_in  = req_ch.received_byte;
                  data_index_in = byte_position_ff;
                  done_res_in   = 1'b1;
               end
            end
            PH_WDATA: begin
               if (st != ST_TXD_ACK) begin
                  error_code_in = ERR_WDATA;
               end else begin
                  phase_in    = PH_IDLE;
                  action_in   = ACT_STOP;
                  done_res_in = 1'b1;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
         // any failed check ends the transfer sequence without a stop
         if (error_code_in != ERR_OK || !emit) begin
            phase_in  = PH_IDLE;
            action_in = ACT_NONE;
         end
         if (error_code_in != ERR_OK) begin
            done_res_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         target_device_ff   <= '0;
         target_register_ff <= '0;
         pending_write_ff   <= '0;
         burst_length_ff    <= '0;
         byte_position_ff   <= '0;
         is_read_ff         <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         if (req_xfer) begin
            phase_ff           <= phase_in;
            target_device_ff   <= target_device_in;
            target_register_ff <= target_register_in;
            pending_write_ff   <= pending_write_in;
            burst_length_ff    <= burst_length_in;
            byte_position_ff   <= byte_position_in;
            is_read_ff         <= is_read_in;
         end
         if (req_xfer && emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && emit) begin
         action_ff     <= action_in;
         tx_byte_ff    <= tx_byte_in;
         data_valid_ff <= data_valid_in;
         data_byte_ff  <= data_byte_in;
         data_index_ff <= data_index_in;
         done_res_ff   <= done_res_in;
         error_code_ff <= error_code_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.action     = action_ff;
   assign rsp_ch.tx_byte    = tx_byte_ff;
   assign rsp_ch.data_valid = data_valid_ff;
   assign rsp_ch.data_byte  = data_byte_ff;
   assign rsp_ch.data_index = data_index_ff;
   assign rsp_ch.done_res   = done_res_ff;
   assign rsp_ch.error_code = error_code_ff;

   a_err_ends: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && error_code_ff != ERR_OK) |->
         (done_res_ff && action_ff == ACT_NONE && phase_ff == PH_IDLE))
      else $error("error result did not end the transaction");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && emit && done_res_in) |=> (phase_ff == PH_IDLE))
      else $error("phase not idle after a finished transaction");

   a_data_action: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && data_valid_ff) |->
         (action_ff == ACT_RACK || action_ff == ACT_RNACK || action_ff == ACT_STOP))
      else $error("read data reported with a non-receive action");

   a_start_from_idle: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && emit && req_ch.command != CMD_STATUS) |-> (phase_ff == PH_IDLE))
      else $error("start accepted while busy");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |=> (out_valid_ff && $stable(action_ff)))
      else $error("stalled result lost");

endmodule
